>>> hw/rtl/bbs_pkg.sv
package bbs_pkg;

	localparam int PRICE_FIELD_W = 32;
	localparam int BAND_FIELD_W  = 32;
	localparam int CFG_IDX_W     = 2;
	localparam int CFG_DATA_W    = 16;
	localparam int WLEN_W        = 7;
	localparam int MULT_W        = 16;
	localparam int MULT_FRAC     = 12;

	localparam logic [CFG_IDX_W-1:0] CFG_WINDOW_LENGTH   = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_BAND_MULTIPLIER = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_BAND_SIDE       = 2'd2;

	localparam logic [WLEN_W-1:0] WLEN_RESET = 7'd20;
	localparam logic [MULT_W-1:0] MULT_RESET = 16'd8192;
	localparam logic              SIDE_RESET = 1'b1;

	typedef enum logic [2:0] {
		S_IDLE,
		S_CHECK,
		S_SUM,
		S_DIV_MEAN,
		S_VAR,
		S_DIV_VAR,
		S_SQRT,
		S_BAND
	} state_t;

	typedef enum logic [3:0] {
		OP_NONE,
		OP_STORE,
		OP_SUM_INIT,
		OP_SUM,
		OP_DIV_INIT,
		OP_DIV,
		OP_VAR_INIT,
		OP_VAR,
		OP_SQRT_INIT,
		OP_SQRT,
		OP_SCALE,
		OP_BAND
	} op_t;

	typedef struct packed {
		op_t op;
	} cmd_t;

	typedef struct packed {
		logic fill_ok;
		logic pass_done;
		logic div_done;
		logic sqrt_done;
	} sts_t;

endpackage

>>> hw/rtl/bbs_if.sv
interface bbs_price_if;
	import bbs_pkg::*;
	logic                     valid;
	logic                     ready;
	logic [PRICE_FIELD_W-1:0] close_price;
	modport source (output valid, output close_price, input ready);
	modport sink (input valid, input close_price, output ready);
endinterface

interface bbs_band_if;
	import bbs_pkg::*;
	logic                    valid;
	logic                    ready;
	logic [BAND_FIELD_W-1:0] band_value;
	logic                    band_saturated;
	modport source (output valid, output band_value, output band_saturated, input ready);
	modport sink (input valid, input band_value, input band_saturated, output ready);
endinterface

>>> hw/rtl/bollinger_band_stream_top.sv
// Bollinger band over a sliding window of close prices (Q16.16).
// Input channel "price": one close price per transfer. Output channel "band":
// one band value plus a clamp flag per price, once the window holds N prices;
// earlier prices produce no transfer.
// Configuration: cfg_wr_en with cfg_index 0 = window length N (2..MAX_WINDOW),
// 1 = multiplier k (Q4.12), 2 = side (1 upper, 0 lower). Write only while idle.
// One price is processed at a time. A price that yields a result takes two passes
// over the window RAM port, two bit-serial divisions by N and a bit-serial square
// root. A price that yields no result is stored and the block returns to idle.
// The result sits in an output register; the next price is taken while it waits.
// A stalled receiver holds the result; the block then stops before writing the
// next result until the transfer completes.
// Reset clears the write position and fill count and restores N = 20, k = 2.0,
// upper side; the window RAM is not cleared and is never read before written.
module bollinger_band_stream_top #(
	parameter int MAX_WINDOW = 64,
	parameter int PRICE_BITS = 32
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_wr_en,
	input  logic [bbs_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [bbs_pkg::CFG_DATA_W-1:0] cfg_data,
	bbs_price_if.sink                      price,
	bbs_band_if.source                     band
);
	import bbs_pkg::*;

	cmd_t cmd;
	sts_t sts;

	bbs_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (price.valid),
		.in_ready  (price.ready),
		.out_valid (band.valid),
		.out_ready (band.ready),
		.cmd       (cmd),
		.sts       (sts)
	);

	bbs_dp #(.MAX_WINDOW(MAX_WINDOW), .PRICE_BITS(PRICE_BITS)) u_dp (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg_wr_en      (cfg_wr_en),
		.cfg_index      (cfg_index),
		.cfg_data       (cfg_data),
		.close_price    (price.close_price),
		.cmd            (cmd),
		.sts            (sts),
		.band_value     (band.band_value),
		.band_saturated (band.band_saturated)
	);
endmodule

>>> hw/rtl/bbs_ram.sv
module bbs_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end
endmodule

>>> hw/rtl/bbs_ctrl.sv
module bbs_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_ready,
	output logic          out_valid,
	input  logic          out_ready,
	output bbs_pkg::cmd_t cmd,
	input  bbs_pkg::sts_t sts
);
	import bbs_pkg::*;

	state_t state_q, state_d;
	logic   out_valid_q;
	logic   out_free;

	assign out_free = !out_valid_q || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q     <= state_d;
			out_valid_q <= (cmd.op == OP_BAND) || (out_valid_q && !out_ready);
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE:     if (in_valid) state_d = S_CHECK;
			S_CHECK:    state_d = sts.fill_ok ? S_SUM : S_IDLE;
			S_SUM:      if (sts.pass_done) state_d = S_DIV_MEAN;
			S_DIV_MEAN: if (sts.div_done) state_d = S_VAR;
			S_VAR:      if (sts.pass_done) state_d = S_DIV_VAR;
			S_DIV_VAR:  if (sts.div_done) state_d = S_SQRT;
			S_SQRT:     if (sts.sqrt_done) state_d = S_BAND;
			S_BAND:     if (out_free) state_d = S_IDLE;
			default:    state_d = S_IDLE;
		endcase
	end

	always_comb begin
		cmd.op = OP_NONE;
		unique case (state_q)
			S_IDLE:     cmd.op = in_valid ? OP_STORE : OP_NONE;
			S_CHECK:    cmd.op = sts.fill_ok ? OP_SUM_INIT : OP_NONE;
			S_SUM:      cmd.op = sts.pass_done ? OP_DIV_INIT : OP_SUM;
			S_DIV_MEAN: cmd.op = sts.div_done ? OP_VAR_INIT : OP_DIV;
			S_VAR:      cmd.op = sts.pass_done ? OP_DIV_INIT : OP_VAR;
			S_DIV_VAR:  cmd.op = sts.div_done ? OP_SQRT_INIT : OP_DIV;
			S_SQRT:     cmd.op = sts.sqrt_done ? OP_SCALE : OP_SQRT;
			S_BAND:     cmd.op = out_free ? OP_BAND : OP_NONE;
			default:    cmd.op = OP_NONE;
		endcase
	end

	assign in_ready  = (state_q == S_IDLE);
	assign out_valid = out_valid_q;
endmodule

>>> hw/rtl/bbs_dp.sv
module bbs_dp #(
	parameter int MAX_WINDOW = 64,
	parameter int PRICE_BITS = 32
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_wr_en,
	input  logic [bbs_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [bbs_pkg::CFG_DATA_W-1:0]    cfg_data,
	input  logic [bbs_pkg::PRICE_FIELD_W-1:0] close_price,
	input  bbs_pkg::cmd_t                     cmd,
	output bbs_pkg::sts_t                     sts,
	output logic [bbs_pkg::BAND_FIELD_W-1:0]  band_value,
	output logic                              band_saturated
);
	import bbs_pkg::*;

	localparam int PB   = PRICE_BITS;
	localparam int AWR  = $clog2(MAX_WINDOW);
	localparam int NW   = $clog2(MAX_WINDOW + 1);
	localparam int LW   = (NW > WLEN_W) ? NW : WLEN_W;
	localparam int ACCW = 2 * PB + NW;
	localparam int DCW  = $clog2(ACCW + 1);
	localparam int SCW  = $clog2(PB + 1);
	localparam int PRW  = MULT_W + PB;
	localparam int OFW  = PRW - MULT_FRAC;
	localparam int BSW  = OFW + 1;

	logic [WLEN_W-1:0] wlen_q;
	logic [MULT_W-1:0] mult_q;
	logic              side_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wlen_q <= WLEN_RESET;
			mult_q <= MULT_RESET;
			side_q <= SIDE_RESET;
		end else if (cfg_wr_en) begin
			unique case (cfg_index)
				CFG_WINDOW_LENGTH:   wlen_q <= cfg_data[WLEN_W-1:0];
				CFG_BAND_MULTIPLIER: wlen_q <= wlen_q;
				default:             wlen_q <= wlen_q;
			endcase
			if (cfg_index == CFG_BAND_MULTIPLIER) mult_q <= cfg_data[MULT_W-1:0];
			if (cfg_index == CFG_BAND_SIDE) side_q <= cfg_data[0];
		end
	end

	logic [LW-1:0] wlen_e;
	logic [NW-1:0] n_clamp;
	assign wlen_e = LW'(wlen_q);
	always_comb begin
		if (wlen_e < LW'(2)) n_clamp = NW'(2);
		else if (wlen_e > LW'(MAX_WINDOW)) n_clamp = NW'(MAX_WINDOW);
		else n_clamp = NW'(wlen_e);
	end

	logic [AWR-1:0] wp_q, first_q, rd_addr_q;
	logic [NW-1:0]  fill_q, n_q, issue_q, cnt_q;
	logic           v_s1, v_s2, v_s3;
	logic [PB-1:0]  price_m, rdata, d_s2, mean_q;
	logic [2*PB-1:0] sq_s3;
	logic [ACCW-1:0] acc_q, div_q;
	logic [NW-1:0]   rem_q;
	logic [DCW-1:0]  dcnt_q;
	logic [2*PB-1:0] rad_q;
	logic [PB-1:0]   root_q;
	logic [PB+1:0]   srem_q;
	logic [SCW-1:0]  scnt_q;
	logic [PRW-1:0]  prod_q;
	logic [PB-1:0]   band_q;
	logic            sat_q;
	logic            pass_op, issue;

	assign price_m = PB'(close_price);
	assign pass_op = (cmd.op == OP_SUM) || (cmd.op == OP_VAR);
	assign issue   = pass_op && (issue_q != n_q);

	bbs_ram #(.WIDTH(PB), .DEPTH(MAX_WINDOW)) u_ram (
		.clk   (clk),
		.we    (cmd.op == OP_STORE),
		.waddr (wp_q),
		.wdata (price_m),
		.re    (issue),
		.raddr (rd_addr_q),
		.rdata (rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q    <= '0;
			fill_q  <= '0;
			v_s1    <= 1'b0;
			v_s2    <= 1'b0;
			v_s3    <= 1'b0;
			issue_q <= '0;
			cnt_q   <= '0;
			dcnt_q  <= '0;
			scnt_q  <= '0;
		end else begin
			v_s1 <= issue;
			v_s2 <= (cmd.op == OP_VAR) && v_s1;
			v_s3 <= (cmd.op == OP_VAR) && v_s2;
			unique case (cmd.op) inside
				OP_STORE: begin
					wp_q <= (wp_q == AWR'(MAX_WINDOW - 1)) ? '0 : wp_q + AWR'(1);
					if (fill_q != NW'(MAX_WINDOW)) fill_q <= fill_q + NW'(1);
				end
				OP_SUM_INIT, OP_VAR_INIT: begin
					issue_q <= '0;
					cnt_q   <= '0;
				end
				OP_SUM: begin
					if (issue) issue_q <= issue_q + NW'(1);
					if (v_s1) cnt_q <= cnt_q + NW'(1);
				end
				OP_VAR: begin
					if (issue) issue_q <= issue_q + NW'(1);
					if (v_s3) cnt_q <= cnt_q + NW'(1);
				end
				OP_DIV_INIT:  dcnt_q <= '0;
				OP_DIV:       dcnt_q <= dcnt_q + DCW'(1);
				OP_SQRT_INIT: scnt_q <= '0;
				OP_SQRT:      scnt_q <= scnt_q + SCW'(1);
				default:      cnt_q <= cnt_q;
			endcase
		end
	end

	logic [NW:0]     rem_sh, rem_sub;
	logic            dge;
	logic [PB+3:0]   sq_sh, trial;
	logic            sge;
	logic [BSW-1:0]  up_sum;
	logic [OFW-1:0]  offset, mean_e;

	assign rem_sh  = {rem_q, div_q[ACCW-1]};
	assign dge     = rem_sh >= {1'b0, n_q};
	assign rem_sub = rem_sh - {1'b0, n_q};
	assign sq_sh   = {srem_q, rad_q[2*PB-1 -: 2]};
	assign trial   = {2'b00, root_q, 2'b01};
	assign sge     = sq_sh >= trial;
	assign offset  = prod_q[PRW-1:MULT_FRAC];
	assign mean_e  = OFW'(mean_q);
	assign up_sum  = BSW'(mean_q) + BSW'(offset);

	always_ff @(posedge clk) begin
		d_s2  <= (rdata >= mean_q) ? rdata - mean_q : mean_q - rdata;
		sq_s3 <= d_s2 * d_s2;
		unique case (cmd.op) inside
			OP_STORE: begin
				n_q       <= n_clamp;
				first_q   <= wp_q;
			end
			OP_SUM_INIT: begin
				rd_addr_q <= first_q;
				acc_q     <= '0;
			end
			OP_VAR_INIT: begin
				rd_addr_q <= first_q;
				acc_q     <= '0;
				mean_q    <= div_q[PB-1:0];
			end
			OP_SUM, OP_VAR: begin
				if (issue) rd_addr_q <= (rd_addr_q == '0) ? AWR'(MAX_WINDOW - 1)
					: rd_addr_q - AWR'(1);
				if (cmd.op == OP_SUM && v_s1) acc_q <= acc_q + ACCW'(rdata);
				if (cmd.op == OP_VAR && v_s3) acc_q <= acc_q + ACCW'(sq_s3);
			end
			OP_DIV_INIT: begin
				div_q <= acc_q;
				rem_q <= '0;
			end
			OP_DIV: begin
				div_q <= {div_q[ACCW-2:0], dge};
				rem_q <= dge ? rem_sub[NW-1:0] : rem_sh[NW-1:0];
			end
			OP_SQRT_INIT: begin
				rad_q  <= div_q[2*PB-1:0];
				root_q <= '0;
				srem_q <= '0;
			end
			OP_SQRT: begin
				rad_q  <= {rad_q[2*PB-3:0], 2'b00};
				root_q <= {root_q[PB-2:0], sge};
				srem_q <= sge ? (PB+2)'(sq_sh - trial) : (PB+2)'(sq_sh);
			end
			OP_SCALE: prod_q <= mult_q * root_q;
			OP_BAND: begin
				if (side_q) begin
					if (up_sum > BSW'({PB{1'b1}})) begin
						band_q <= {PB{1'b1}};
						sat_q  <= 1'b1;
					end else begin
						band_q <= PB'(up_sum);
						sat_q  <= 1'b0;
					end
				end else begin
					if (offset > mean_e) begin
						band_q <= '0;
						sat_q  <= 1'b1;
					end else begin
						band_q <= PB'(mean_e - offset);
						sat_q  <= 1'b0;
					end
				end
			end
			default: band_q <= band_q;
		endcase
	end

	assign sts.fill_ok   = (fill_q >= n_q);
	assign sts.pass_done = (cnt_q == n_q);
	assign sts.div_done  = (dcnt_q == DCW'(ACCW));
	assign sts.sqrt_done = (scnt_q == SCW'(PB));

	assign band_value     = BAND_FIELD_W'(band_q);
	assign band_saturated = sat_q;
endmodule

>>> bench/bollinger_band_stream_top_test.sv
module bollinger_band_stream_top_test;
	import bbs_pkg::*;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int WIN_DEPTH = 64;

	typedef struct {
		logic [BAND_FIELD_W-1:0] value;
		logic                    saturated;
	} band_result_t;

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  cfg_wr_en = 1'b0;
	logic [CFG_IDX_W-1:0]  cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data = '0;

	bbs_price_if price ();
	bbs_band_if  band ();

	bollinger_band_stream_top dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_wr_en (cfg_wr_en),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.price     (price.sink),
		.band      (band.source)
	);

	always #5 clk = ~clk;

	logic [PRICE_FIELD_W-1:0] price_backlog[$];
	band_result_t             band_expect[$];

	logic [PRICE_FIELD_W-1:0] window_store[WIN_DEPTH];
	int unsigned              store_pos;
	int unsigned              stored_count;
	logic [WLEN_W-1:0]        mirror_wlen;
	logic [MULT_W-1:0]        mirror_mult;
	logic                     mirror_side;

	bit          stalls_on = 1'b1;
	int unsigned fail_count;
	int unsigned prices_sent;
	int unsigned bands_checked;
	int unsigned sat_seen;
	int unsigned src_gap;
	int unsigned snk_gap;

	function automatic logic [127:0] int_sqrt(input logic [127:0] v);
		logic [127:0] root;
		logic [127:0] cand;
		root = '0;
		for (int b = 63; b >= 0; b--) begin
			cand = root | (128'd1 << b);
			if (cand * cand <= v)
				root = cand;
		end
		return root;
	endfunction

	task automatic record_price(input logic [PRICE_FIELD_W-1:0] p);
		int unsigned  n;
		int unsigned  idx;
		logic [71:0]  sum;
		logic [71:0]  mean;
		logic [71:0]  dev;
		logic [127:0] acc;
		logic [127:0] sd;
		logic [127:0] offset;
		logic [127:0] total;
		band_result_t r;
		window_store[store_pos] = p;
		store_pos = (store_pos + 1 >= WIN_DEPTH) ? 0 : store_pos + 1;
		if (stored_count < WIN_DEPTH)
			stored_count++;
		n = mirror_wlen;
		if (n < 2)
			n = 2;
		if (n > WIN_DEPTH)
			n = WIN_DEPTH;
		if (stored_count < n)
			return;
		sum = '0;
		for (int i = 0; i < n; i++) begin
			idx = (store_pos + WIN_DEPTH - 1 - i) % WIN_DEPTH;
			sum += window_store[idx];
		end
		mean = sum / n;
		acc = '0;
		for (int i = 0; i < n; i++) begin
			idx = (store_pos + WIN_DEPTH - 1 - i) % WIN_DEPTH;
			dev = (window_store[idx] >= mean) ? window_store[idx] - mean
				: mean - window_store[idx];
			acc += dev * dev;
		end
		sd = int_sqrt(acc / n);
		offset = (mirror_mult * sd) >> MULT_FRAC;
		r.saturated = 1'b0;
		if (mirror_side) begin
			total = mean + offset;
			if (total > 128'hFFFF_FFFF) begin
				total = 128'hFFFF_FFFF;
				r.saturated = 1'b1;
			end
		end else begin
			if (offset > mean) begin
				total = '0;
				r.saturated = 1'b1;
			end else begin
				total = mean - offset;
			end
		end
		r.value = total[BAND_FIELD_W-1:0];
		band_expect = {band_expect, r};
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			price.valid <= 1'b0;
			price.close_price <= '0;
			src_gap <= 0;
		end else begin
			if (price.valid && price.ready) begin
				record_price(price.close_price);
				prices_sent++;
			end
			if (!price.valid || price.ready) begin
				if (src_gap > 0) begin
					src_gap <= src_gap - 1;
					price.valid <= 1'b0;
				end else if (price_backlog.size() > 0 && stalls_on
						&& $urandom_range(0, 11) == 0) begin
					src_gap <= $urandom_range(0, 17);
					price.valid <= 1'b0;
				end else if (price_backlog.size() > 0) begin
					price.valid <= 1'b1;
					price.close_price <= price_backlog.pop_front();
				end else begin
					price.valid <= 1'b0;
				end
			end
		end
	end

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			band.ready <= 1'b0;
			snk_gap <= 0;
		end else begin
			if (band.valid && band.ready) begin
				if (band_expect.size() == 0) begin
					$error("unexpected band transfer: band_value %0h", band.band_value);
					fail_count++;
				end else begin
					band_result_t e;
					e = band_expect.pop_front();
					bands_checked++;
					if (e.saturated)
						sat_seen++;
					if (band.band_value !== e.value) begin
						$error("band_value expected %0h actual %0h", e.value, band.band_value);
						fail_count++;
					end
					if (band.band_saturated !== e.saturated) begin
						$error("band_saturated expected %0b actual %0b",
							e.saturated, band.band_saturated);
						fail_count++;
					end
				end
			end
			if (snk_gap > 0) begin
				snk_gap <= snk_gap - 1;
				band.ready <= 1'b0;
			end else if (stalls_on && $urandom_range(0, 9) == 0) begin
				snk_gap <= $urandom_range(0, 17);
				band.ready <= 1'b0;
			end else begin
				band.ready <= 1'b1;
			end
		end
	end

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int unsigned val);
		@(posedge clk);
		cfg_wr_en <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val[CFG_DATA_W-1:0];
		case (idx)
			CFG_WINDOW_LENGTH: mirror_wlen = val[WLEN_W-1:0];
			CFG_BAND_MULTIPLIER: mirror_mult = val[MULT_W-1:0];
			CFG_BAND_SIDE: mirror_side = val[0];
			default: ;
		endcase
		@(posedge clk);
		cfg_wr_en <= 1'b0;
	endtask

	task automatic set_band(input int unsigned wlen, input int unsigned mult,
			input int unsigned side);
		write_reg(CFG_WINDOW_LENGTH, wlen);
		write_reg(CFG_BAND_MULTIPLIER, mult);
		write_reg(CFG_BAND_SIDE, side);
	endtask

	task automatic drain();
		do begin
			@(posedge clk);
			#1;
		end while (price_backlog.size() > 0 || price.valid || band_expect.size() > 0);
		repeat (8) @(posedge clk);
	endtask

	function automatic logic [31:0] pick_price(input logic [31:0] base);
		case ($urandom_range(0, 5))
			0: return $urandom();
			1: return ($urandom_range(0, 1) == 0) ? 32'h0 : 32'hFFFF_FFFF;
			2: return base ^ (32'h1 << $urandom_range(0, 31));
			default: return base + $urandom_range(0, 4095) - 2048;
		endcase
	endfunction

	initial begin
		int unsigned  wlen;
		int unsigned  mult;
		int unsigned  cnt;
		logic [31:0]  base;
		mirror_wlen = WLEN_RESET;
		mirror_mult = MULT_RESET;
		mirror_side = SIDE_RESET;
		store_pos = 0;
		stored_count = 0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;

		price_backlog = '{32'h0, 32'hFFFF_FFFF, 32'h0001_0000, 32'h5555_5555, 32'hAAAA_AAAA};
		for (int i = 0; i < 18; i++)
			price_backlog = {price_backlog, 32'h0064_0000 + i * 32'h0000_8000};
		drain();

		set_band(2, 65535, 1);
		price_backlog = '{32'hFFFF_FFFF, 32'h0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h1};
		drain();
		set_band(2, 65535, 0);
		price_backlog = '{32'h0, 32'hFFFF_FFFF, 32'h0, 32'h0, 32'h7FFF_FFFF};
		drain();
		set_band(0, 0, 1);
		price_backlog = '{32'h1234_5678, 32'h8765_4321};
		drain();
		set_band(127, 4096, 0);
		for (int i = 0; i < 66; i++)
			price_backlog = {price_backlog, (i[0] ? 32'hFFFF_FFFF : 32'h0)};
		drain();

		for (int ph = 0; ph < 14; ph++) begin
			if ($urandom_range(0, 4) == 0)
				wlen = ($urandom_range(0, 1) == 0) ? 64 : $urandom_range(0, 127);
			else
				wlen = $urandom_range(0, 12);
			case ($urandom_range(0, 3))
				0: mult = 0;
				1: mult = 65535;
				default: mult = $urandom_range(0, 65535);
			endcase
			set_band(wlen, mult, $urandom_range(0, 1));
			if (ph == 13)
				stalls_on = 1'b0;
			cnt = (wlen > 16 && wlen < 128) ? 60 : 160;
			base = $urandom();
			for (int i = 0; i < cnt; i++)
				price_backlog = {price_backlog, pick_price(base)};
			drain();
		end

		$display("covered %0d prices and %0d band results (%0d clamped)",
			prices_sent, bands_checked, sat_seen);
		$display("window lengths 0..127, multipliers 0..65535, both band sides");
		if (fail_count == 0)
			$display("PASSED: all results match");
		else
			$display("FAILED: results differ");
		$finish;
	end

	initial begin
		#60ms;
		$display("FAILED: results differ");
		$finish;
	end

endmodule

>>> filelist.f
hw/rtl/bbs_pkg.sv
hw/rtl/bbs_if.sv
hw/rtl/bbs_ram.sv
hw/rtl/bbs_ctrl.sv
hw/rtl/bbs_dp.sv
hw/rtl/bollinger_band_stream_top.sv
bench/bollinger_band_stream_top_test.sv
